// ----- rtl/plar_pkg.sv -----
// ----------------------------------------------------------------------------
// plar_pkg
// Types, constants and small tables shared by the anchor resampler modules.
// ----------------------------------------------------------------------------
package plar_pkg;

    localparam int FRAC_BITS        = 8;
    localparam int TILE_EXTENT      = 4096;
    localparam int MAX_SEGMENTS     = 4096;
    localparam int DEF_MAX_ANCHORS  = 64;

    localparam int SEG_LIMIT        = (MAX_SEGMENTS < 4096) ? MAX_SEGMENTS : 4096;
    localparam logic [11:0] SEG_CAP = 12'(SEG_LIMIT - 1);

    localparam int ROOT_W           = 25;
    localparam int ANGLE_LIMIT      = 25736;
    localparam int PI_Q16           = 205887;

    // configuration register indexes
    localparam logic [1:0] CFG_SPACING    = 2'd0;
    localparam logic [1:0] CFG_MAX_SCALE  = 2'd1;
    localparam logic [1:0] CFG_TILE_RATIO = 2'd2;
    localparam logic [1:0] CFG_OFFSET     = 2'd3;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               first_vertex;
    } vertex_t;

    typedef struct packed {
        logic [19:0]        anchor_x;
        logic [19:0]        anchor_y;
        logic signed [15:0] anchor_angle;
        logic [4:0]         scale_halves;
        logic [11:0]        segment_number;
        logic               last_of_run;
        logic               truncated;
    } anchor_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SQUARE,
        ST_LAUNCH,
        ST_WAIT,
        ST_DECIDE,
        ST_TRUNC,
        ST_LOOP,
        ST_MUL,
        ST_DIVSTART,
        ST_DIVWAIT,
        ST_PLACE,
        ST_FLUSH,
        ST_COMMIT
    } plar_state_t;

    // arctangent of 2^-i in Q.16 radians
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30385;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    // minimum scale in halves for a pattern level and position
    function automatic logic [4:0] pattern_scale(input logic [1:0] level,
                                                 input logic [2:0] pos);
        logic [4:0] v;
        case (level)
            2'd0:    v = 5'd1;
            2'd1:    v = pos[0] ? 5'd4 : 5'd1;
            2'd2:    v = pos[0] ? 5'd8 : (pos[1] ? 5'd4 : 5'd1);
            default: v = pos[0] ? 5'd16 : (pos[1] ? 5'd8 : (pos[2] ? 5'd4 : 5'd1));
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/plar_div.sv -----
// ----------------------------------------------------------------------------
// plar_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plar_div #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  take;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, divisor_reg};
        take     = shifted >= {1'b0, divisor_reg};
        rem_next = take ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], take};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/plar_sqrt.sv -----
// ----------------------------------------------------------------------------
// plar_sqrt
// Digit-by-digit square root of the squared segment length, two radicand
// bits per cycle, giving the length with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module plar_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [33:0]                radicand,
    output logic                       busy,
    output logic [plar_pkg::ROOT_W-1:0] root
);
    import plar_pkg::*;

    localparam int SRC_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SRC_W-1:0]  src_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              busy_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], src_reg[SRC_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            src_reg  <= SRC_W'({radicand, {(2 * FRAC_BITS){1'b0}}});
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            src_reg  <= {src_reg[SRC_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- rtl/plar_cordic.sv -----
// ----------------------------------------------------------------------------
// plar_cordic
// Vectoring CORDIC for the segment direction, one rotation per cycle.
// ----------------------------------------------------------------------------
module plar_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    output logic               busy,
    output logic signed [15:0] angle
);
    import plar_pkg::*;

    localparam int X_W = 36;
    localparam int Z_W = 21;

    logic signed [X_W-1:0] x_reg;
    logic signed [X_W-1:0] y_reg;
    logic signed [Z_W-1:0] z_reg;
    logic [3:0]            iter_reg;
    logic                  busy_reg;

    logic signed [X_W-1:0] x0;
    logic signed [X_W-1:0] y0;
    logic signed [X_W-1:0] xs;
    logic signed [X_W-1:0] ys;
    logic signed [Z_W-1:0] step;
    logic signed [Z_W:0]   zr;
    logic signed [Z_W:0]   zq;

    always_comb
    begin
        x0   = X_W'({dx, 16'd0});
        y0   = X_W'({dy, 16'd0});
        x0   = {{(X_W-33){dx[16]}}, dx, 16'd0};
        y0   = {{(X_W-33){dy[16]}}, dy, 16'd0};
        xs   = x_reg >>> iter_reg;
        ys   = y_reg >>> iter_reg;
        step = $signed({{(Z_W-16){1'b0}}, atan_q16(iter_reg)});
        zr   = {z_reg[Z_W-1], z_reg} + (Z_W+1)'(4);
        zq   = zr >>> 3;
        if (zq > (Z_W+1)'(ANGLE_LIMIT))
            angle = 16'(ANGLE_LIMIT);
        else if (zq < -(Z_W+1)'(ANGLE_LIMIT))
            angle = -16'(ANGLE_LIMIT);
        else
            angle = zq[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end
        else if (busy_reg)
        begin
            iter_reg <= iter_reg + 1'b1;
            if (iter_reg == 4'd15)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // fold the left half plane onto the right
            if (dx[16])
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= dy[16] ? -Z_W'(PI_Q16) : Z_W'(PI_Q16);
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[X_W-1])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step;
            end
        end
    end

    assign busy = busy_reg;

endmodule

// ----- rtl/polyline_anchor_resampler.sv -----
// ----------------------------------------------------------------------------
// polyline_anchor_resampler
// Places anchors at equal spacing along a polyline fed one vertex per item.
// ----------------------------------------------------------------------------
// Operation: for a vertex, spacing, length and angle are computed in parallel (the
//   spacing divider is the slowest of the three), then each anchor on the segment
//   waits on the interpolation dividers, plus output stalls.
// Throughput: one vertex at a time; a new vertex is taken once all anchors
//   of the previous one have been handed to the output register.
// Reset: asynchronous, active low; control, configuration and line registers take their defaults, no line open.
module polyline_anchor_resampler #(
    parameter int MAX_ANCHORS_PER_SEGMENT = plar_pkg::DEF_MAX_ANCHORS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              vertex_valid,
    output logic              vertex_ready,
    input  plar_pkg::vertex_t vertex,
    output logic              anchor_valid,
    input  logic              anchor_ready,
    output plar_pkg::anchor_t anchor,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data
);
    import plar_pkg::*;

    localparam int PLACED_W = $clog2(MAX_ANCHORS_PER_SEGMENT + 1);
    localparam logic [38:0] TCOUNT = 39'(MAX_ANCHORS_PER_SEGMENT + 1);
    localparam logic signed [25:0] LIMIT = 26'(TILE_EXTENT * (2 ** FRAC_BITS));
    localparam logic signed [35:0] MARK_MAX = 36'sd4294967295;
    localparam logic signed [35:0] MARK_MIN = -36'sd4294967296;

    plar_state_t state_reg, state_next;

    // configuration
    logic [23:0] spacing_reg;
    logic [15:0] max_scale_reg;
    logic [15:0] tpr_reg;
    logic [23:0] offset_reg;

    // line state
    logic signed [15:0] prev_x_reg, prev_y_reg;
    logic               have_prev_reg;
    logic [31:0]        trav_reg;
    logic signed [32:0] mark_reg;
    logic [2:0]         acount_reg;
    logic [11:0]        seg_reg;

    // per-vertex working values
    logic signed [15:0] vx_reg, vy_reg;
    logic               first_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic [32:0]        sqx_reg, sqy_reg;
    logic [39:0]        prod_sp_reg, prod_off_reg;
    logic [3:0]         scale_reg;
    logic [31:0]        sp_reg, off_reg;
    logic [ROOT_W-1:0]  len_reg;
    logic signed [15:0] ang_reg;
    logic [32:0]        end_reg;
    logic [38:0]        tprod_reg;
    logic               trunc_reg;
    logic signed [35:0] mk_reg;
    logic [PLACED_W-1:0] placed_reg;
    logic [ROOT_W-1:0]  along_reg;
    logic [41:0]        mulx_reg, muly_reg;
    anchor_t            cand_reg;
    logic               cand_kept_reg;

    // result staging
    anchor_t            pend_reg;
    logic               pend_valid_reg;
    anchor_t            out_reg;
    logic               out_valid_reg;

    // units
    logic               sqrt_busy, cordic_busy, spdiv_busy, xdiv_busy, ydiv_busy;
    logic [ROOT_W-1:0]  root;
    logic signed [15:0] angle;
    logic [32:0]        sp_quot;
    logic [41:0]        xq, yq;
    logic [40:0]        sp_num;
    logic [40:0]        off_num;

    // control
    logic               launch, div_start, slot_free, place_go, push_out, out_last;
    logic               is_start;

    // datapath helpers
    logic [16:0]        ms_sum;
    logic [7:0]         s_raw;
    logic [3:0]         s_clamped;
    logic [1:0]         level;
    logic signed [36:0] mk_step;
    logic               cont;
    logic               cap_hit;
    logic signed [37:0] along_raw;
    logic [ROOT_W-1:0]  along_c;
    logic signed [40:0] tsum;
    logic [15:0]        magx, magy;
    logic [16:0]        dx_neg, dy_neg;
    logic signed [25:0] ax, ay;
    logic signed [25:0] qx_s, qy_s;
    logic signed [32:0] sq_x_full, sq_y_full;
    anchor_t            out_word;

    plar_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (launch),
        .radicand ({1'b0, sqx_reg} + {1'b0, sqy_reg}),
        .busy     (sqrt_busy),
        .root     (root)
    );

    plar_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (launch),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .busy  (cordic_busy),
        .angle (angle)
    );

    plar_div #(.DIVIDEND_W(33), .DIVISOR_W(4)) u_spdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (launch),
        .dividend (sp_num[40:8]),
        .divisor  (scale_reg),
        .busy     (spdiv_busy),
        .quotient (sp_quot)
    );

    plar_div #(.DIVIDEND_W(42), .DIVISOR_W(ROOT_W)) u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mulx_reg),
        .divisor  (len_reg),
        .busy     (xdiv_busy),
        .quotient (xq)
    );

    plar_div #(.DIVIDEND_W(42), .DIVISOR_W(ROOT_W)) u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (muly_reg),
        .divisor  (len_reg),
        .busy     (ydiv_busy),
        .quotient (yq)
    );

    always_comb
    begin
        ms_sum    = {1'b0, max_scale_reg} + 17'd256;
        s_raw     = ms_sum[16:9];
        if (s_raw < 8'd1)
            s_clamped = 4'd1;
        else if (s_raw > 8'd8)
            s_clamped = 4'd8;
        else
            s_clamped = s_raw[3:0];

        if (scale_reg >= 4'd8)
            level = 2'd3;
        else if (scale_reg >= 4'd4)
            level = 2'd2;
        else if (scale_reg >= 4'd2)
            level = 2'd1;
        else
            level = 2'd0;

        sp_num  = {1'b0, prod_sp_reg} + 41'({scale_reg, 7'd0});
        off_num = {1'b0, prod_off_reg} + 41'd128;

        sq_x_full = 33'(dx_reg * dx_reg);
        sq_y_full = 33'(dy_reg * dy_reg);

        mk_step = $signed({mk_reg[35], mk_reg}) + $signed({5'd0, sp_reg});
        cont    = mk_step < $signed({4'd0, end_reg});
        cap_hit = placed_reg >= PLACED_W'(MAX_ANCHORS_PER_SEGMENT);

        along_raw = $signed({mk_step[36], mk_step}) - $signed({6'd0, trav_reg});
        if (along_raw < 0)
            along_c = '0;
        else if (along_raw > $signed({13'd0, len_reg}))
            along_c = len_reg;
        else
            along_c = along_raw[ROOT_W-1:0];

        tsum = $signed({{5{mk_reg[35]}}, mk_reg}) + $signed({2'b0, tprod_reg});

        dx_neg = -dx_reg;
        dy_neg = -dy_reg;
        magx   = dx_reg[16] ? dx_neg[15:0] : dx_reg[15:0];
        magy   = dy_reg[16] ? dy_neg[15:0] : dy_reg[15:0];

        qx_s = dx_reg[16] ? -$signed({1'b0, xq[ROOT_W-1:0]})
                          : $signed({1'b0, xq[ROOT_W-1:0]});
        qy_s = dy_reg[16] ? -$signed({1'b0, yq[ROOT_W-1:0]})
                          : $signed({1'b0, yq[ROOT_W-1:0]});
        ax   = $signed({{2{prev_x_reg[15]}}, prev_x_reg, {FRAC_BITS{1'b0}}}) + qx_s;
        ay   = $signed({{2{prev_y_reg[15]}}, prev_y_reg, {FRAC_BITS{1'b0}}}) + qy_s;

        is_start = first_reg || !have_prev_reg;

        out_word             = pend_reg;
        out_word.last_of_run = out_last;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (vertex_valid) state_next = ST_DELTA;
            ST_DELTA:    state_next = ST_SQUARE;
            ST_SQUARE:   state_next = ST_LAUNCH;
            ST_LAUNCH:   state_next = ST_WAIT;
            ST_WAIT:
                if (!(sqrt_busy || cordic_busy || spdiv_busy))
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (is_start || len_reg == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_TRUNC;
            ST_TRUNC:    state_next = ST_LOOP;
            ST_LOOP:
                if (cont && !cap_hit)
                    state_next = ST_MUL;
                else
                    state_next = ST_FLUSH;
            ST_MUL:      state_next = ST_DIVSTART;
            ST_DIVSTART: state_next = ST_DIVWAIT;
            ST_DIVWAIT:  if (!(xdiv_busy || ydiv_busy)) state_next = ST_PLACE;
            ST_PLACE:    if (place_go) state_next = ST_LOOP;
            ST_FLUSH:    if (!pend_valid_reg || slot_free) state_next = ST_COMMIT;
            ST_COMMIT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        vertex_ready = 1'b0;
        launch       = 1'b0;
        div_start    = 1'b0;
        place_go     = 1'b0;
        push_out     = 1'b0;
        out_last     = 1'b0;
        slot_free    = !out_valid_reg || anchor_ready;
        unique case (state_reg)
            ST_IDLE:     vertex_ready = 1'b1;
            ST_LAUNCH:   launch = 1'b1;
            ST_DIVSTART: div_start = 1'b1;
            ST_PLACE:
            begin
                place_go = !cand_kept_reg || !pend_valid_reg || slot_free;
                push_out = cand_kept_reg && pend_valid_reg && slot_free;
            end
            ST_FLUSH:
            begin
                push_out = pend_valid_reg && slot_free;
                out_last = 1'b1;
            end
            default:     ;
        endcase
    end

    assign cfg_ready    = 1'b1;
    assign anchor_valid = out_valid_reg;
    assign anchor       = out_reg;

    // control, configuration and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            spacing_reg    <= 24'd256;
            max_scale_reg  <= 16'd512;
            tpr_reg        <= 16'd256;
            offset_reg     <= 24'd0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            have_prev_reg  <= 1'b0;
            trav_reg       <= '0;
            mark_reg       <= '0;
            acount_reg     <= '0;
            seg_reg        <= '0;
            placed_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SPACING:    spacing_reg   <= cfg_data;
                    CFG_MAX_SCALE:  max_scale_reg <= cfg_data[15:0];
                    CFG_TILE_RATIO: tpr_reg       <= cfg_data[15:0];
                    CFG_OFFSET:     offset_reg    <= cfg_data;
                endcase
            end

            if (push_out)
                out_valid_reg <= 1'b1;
            else if (anchor_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_DECIDE:
                begin
                    placed_reg <= '0;
                    if (is_start)
                    begin
                        prev_x_reg    <= vx_reg;
                        prev_y_reg    <= vy_reg;
                        have_prev_reg <= 1'b1;
                        trav_reg      <= '0;
                        mark_reg      <= (off_reg != '0)
                                         ? $signed({1'b0, off_reg}) - $signed({1'b0, sp_reg})
                                         : '0;
                        acount_reg    <= '0;
                        seg_reg       <= '0;
                    end
                    else if (len_reg == '0)
                    begin
                        if (seg_reg < SEG_CAP)
                            seg_reg <= seg_reg + 1'b1;
                        prev_x_reg <= vx_reg;
                        prev_y_reg <= vy_reg;
                    end
                end
                ST_LOOP:
                    if (cont && !cap_hit)
                        placed_reg <= placed_reg + 1'b1;
                ST_PLACE:
                    if (place_go)
                    begin
                        acount_reg <= acount_reg + 1'b1;
                        if (cand_kept_reg)
                            pend_valid_reg <= 1'b1;
                    end
                ST_FLUSH:
                    if (push_out)
                        pend_valid_reg <= 1'b0;
                ST_COMMIT:
                begin
                    trav_reg <= end_reg[32] ? '1 : end_reg[31:0];
                    if (mk_reg > MARK_MAX)
                        mark_reg <= MARK_MAX[32:0];
                    else if (mk_reg < MARK_MIN)
                        mark_reg <= MARK_MIN[32:0];
                    else
                        mark_reg <= mk_reg[32:0];
                    if (seg_reg < SEG_CAP)
                        seg_reg <= seg_reg + 1'b1;
                    prev_x_reg <= vx_reg;
                    prev_y_reg <= vy_reg;
                end
                default: ;
            endcase
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (push_out)
            out_reg <= out_word;

        unique case (state_reg)
            ST_IDLE:
                if (vertex_valid)
                begin
                    vx_reg    <= vertex.vertex_x;
                    vy_reg    <= vertex.vertex_y;
                    first_reg <= vertex.first_vertex;
                end
            ST_DELTA:
            begin
                dx_reg       <= {vx_reg[15], vx_reg} - {prev_x_reg[15], prev_x_reg};
                dy_reg       <= {vy_reg[15], vy_reg} - {prev_y_reg[15], prev_y_reg};
                prod_sp_reg  <= 40'(spacing_reg) * 40'(tpr_reg);
                prod_off_reg <= 40'(offset_reg) * 40'(tpr_reg);
                scale_reg    <= s_clamped;
            end
            ST_SQUARE:
            begin
                sqx_reg <= sq_x_full;
                sqy_reg <= sq_y_full;
            end
            ST_LAUNCH:
                off_reg <= off_num[39:8];
            ST_WAIT:
            begin
                sp_reg  <= sp_quot[32] ? '1 : sp_quot[31:0];
                len_reg <= root;
                ang_reg <= angle;
            end
            ST_DECIDE:
            begin
                end_reg   <= {1'b0, trav_reg} + 33'(len_reg);
                tprod_reg <= 39'(sp_reg) * TCOUNT;
                mk_reg    <= 36'(mark_reg);
            end
            ST_TRUNC:
                trunc_reg <= tsum < $signed({8'd0, end_reg});
            ST_LOOP:
                if (cont)
                begin
                    if (cap_hit)
                        mk_reg <= $signed({3'd0, end_reg}) - $signed({4'd0, sp_reg});
                    else
                    begin
                        mk_reg    <= mk_step[35:0];
                        along_reg <= along_c;
                    end
                end
            ST_MUL:
            begin
                mulx_reg <= 42'(magx) * 42'(along_reg) + 42'(len_reg[ROOT_W-1:1]);
                muly_reg <= 42'(magy) * 42'(along_reg) + 42'(len_reg[ROOT_W-1:1]);
            end
            ST_DIVWAIT:
            begin
                cand_reg.anchor_x       <= ax[19:0];
                cand_reg.anchor_y       <= ay[19:0];
                cand_reg.anchor_angle   <= ang_reg;
                cand_reg.scale_halves   <= pattern_scale(level, acount_reg);
                cand_reg.segment_number <= seg_reg;
                cand_reg.last_of_run    <= 1'b0;
                cand_reg.truncated      <= trunc_reg;
                cand_kept_reg           <= (ax >= 0) && (ax < LIMIT) &&
                                           (ay >= 0) && (ay < LIMIT);
            end
            ST_PLACE:
                if (place_go && cand_kept_reg)
                    pend_reg <= cand_reg;
            default: ;
        endcase
    end

endmodule
